// File: hw/rtl/octave_value_noise_2d_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the value noise block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OCTAVE_VALUE_NOISE_2D_DEFINES_SVH
`define OCTAVE_VALUE_NOISE_2D_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent holds in the same cycle as the antecedent
`define OVN_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ovn assertion failed");
// Consequent holds in the cycle after the antecedent
`define OVN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ovn assertion failed");
`else
`define OVN_ASSERT_SAME(lbl, ante, cons)
`define OVN_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/ovn_pkg.sv
// ----------------------------------------------------------------------------
// ovn_pkg
// Types, constants and the cosine weight function of the value noise block.
// ----------------------------------------------------------------------------
package ovn_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int NOISE_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSIST_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ABS_ENABLE = 2'd2;

  // Datapath widths
  localparam int LAT_W = 32;     // lattice index and hash
  localparam int SMOOTH_W = 36;  // smoothed value, units of 2^-34
  localparam int WEIGHT_W = 17;  // Q16 weight, 0..65536
  localparam int SUM4_W = 38;    // sum of four octaves
  localparam int ACC_W = 40;     // full sum and its magnitude
  localparam int OUT_SHIFT = 17;

  // Hash constants
  localparam logic [LAT_W-1:0] HASH_MUL = 32'd15731;
  localparam logic [LAT_W-1:0] HASH_ADD1 = 32'd789221;
  localparam logic [LAT_W-1:0] HASH_ADD2 = 32'd1376312589;
  localparam logic signed [LAT_W-1:0] LAT_ONE = 32'sh4000_0000;

  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 20'sh7ffff;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = 20'sh80000;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Control carried from the top level to each octave
  typedef struct packed {
    logic       en;
    logic [1:0] pshift;
  } oct_ctrl_t;

  // Q16 weight (1 - cos(pi*t))/2, evaluated once per table entry
  function automatic logic [WEIGHT_W-1:0] cos_weight(int unsigned frac, int unsigned fbits);
    longint unsigned one;
    longint unsigned t;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned h;
    longint unsigned w;
    logic            upper;
    one = 64'd1 << 30;
    t = longint'(frac) << (30 - fbits);
    upper = t > (one >> 1);
    if (upper) begin
      t = one - t;
    end
    theta = (t * PI_Q30) >> 30;
    x2 = (theta * theta) >> 30;
    h = one - x2 / 90;
    h = one - ((x2 * h) >> 30) / 56;
    h = one - ((x2 * h) >> 30) / 30;
    h = one - ((x2 * h) >> 30) / 12;
    w = ((x2 * h) >> 30) >> 2;
    if (upper) begin
      w = one - w;
    end
    return WEIGHT_W'((w + 64'd8192) >> 14);
  endfunction

endpackage

// File: hw/rtl/ovn_in_if.sv
// ----------------------------------------------------------------------------
// ovn_in_if
// Coordinate channel: one item is one (x, y) point in Q8.8.
// ----------------------------------------------------------------------------
interface ovn_in_if;
  logic                          valid;
  logic                          ready;
  logic [ovn_pkg::COORD_W-1:0]   x_coord;
  logic [ovn_pkg::COORD_W-1:0]   y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

// File: hw/rtl/ovn_out_if.sv
// ----------------------------------------------------------------------------
// ovn_out_if
// Result channel: one item is one noise sample in Q2.17.
// ----------------------------------------------------------------------------
interface ovn_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ovn_pkg::NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

// File: hw/rtl/ovn_cfg_if.sv
// ----------------------------------------------------------------------------
// ovn_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface ovn_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ovn_pkg::CFG_IDX_W-1:0]  index;
  logic [ovn_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/ovn_hash.sv
// ----------------------------------------------------------------------------
// ovn_hash
// Four-stage integer lattice hash, mapped to a signed Q.30 value.
// ----------------------------------------------------------------------------
module ovn_hash (
  input  logic                             clk,
  input  logic                             en,
  input  logic [ovn_pkg::LAT_W-1:0]        lat_x,
  input  logic [ovn_pkg::LAT_W-1:0]        lat_y,
  output logic signed [ovn_pkg::LAT_W-1:0] lat_val
);

  logic [ovn_pkg::LAT_W-1:0] mix;
  logic [ovn_pkg::LAT_W-1:0] seed_nxt;
  logic [ovn_pkg::LAT_W-1:0] n1_r, n2_r, n3_r;
  logic [ovn_pkg::LAT_W-1:0] sq_r;
  logic [ovn_pkg::LAT_W-1:0] poly_r;
  logic [ovn_pkg::LAT_W-1:0] full;
  logic signed [ovn_pkg::LAT_W-1:0] val_r;

  // Combine coordinates and shift-xor
  assign mix = lat_x + (lat_y << 4) + lat_y;
  assign seed_nxt = (mix << 13) ^ mix;
  assign full = n3_r * poly_r + ovn_pkg::HASH_ADD2;

  // Advance the hash stages
  always_ff @(posedge clk) begin
    if (en) begin
      n1_r <= seed_nxt;
      sq_r <= n1_r * n1_r;
      n2_r <= n1_r;
      poly_r <= sq_r * ovn_pkg::HASH_MUL + ovn_pkg::HASH_ADD1;
      n3_r <= n2_r;
      val_r <= ovn_pkg::LAT_ONE - $signed({1'b0, full[30:0]});
    end
  end

  assign lat_val = val_r;

endmodule

// File: hw/rtl/ovn_octave.sv
// ----------------------------------------------------------------------------
// ovn_octave
// One octave: 4x4 lattice hashes, 3x3 smoothing, two cosine blends, scale.
// ----------------------------------------------------------------------------
module ovn_octave #(
  parameter int FRAC_BITS = 8,
  parameter int OCT = 0
) (
  input  logic                                clk,
  input  ovn_pkg::oct_ctrl_t                  ctrl,
  input  logic [ovn_pkg::COORD_W-1:0]         x_coord,
  input  logic [ovn_pkg::COORD_W-1:0]         y_coord,
  output logic signed [ovn_pkg::SMOOTH_W-1:0] oct_val
);

  localparam int NW = 1 << FRAC_BITS;
  localparam int SW = ovn_pkg::SMOOTH_W;
  localparam int PW = SW + 1 + ovn_pkg::WEIGHT_W + 1;

  logic [ovn_pkg::LAT_W-1:0] sx, sy, xi, yi;
  logic [ovn_pkg::LAT_W-1:0] lx [4];
  logic [ovn_pkg::LAT_W-1:0] ly [4];
  logic signed [ovn_pkg::LAT_W-1:0] lv [4][4];
  logic [FRAC_BITS-1:0] fx_r [4];
  logic [FRAC_BITS-1:0] fy_r [4];
  logic [ovn_pkg::WEIGHT_W-1:0] wtab [NW];
  logic [ovn_pkg::WEIGHT_W-1:0] wx_r, wy_r, wy2_r;
  logic signed [SW-1:0] sm [4];
  logic signed [SW-1:0] sm_r [4];
  logic signed [SW:0] d1, d2, d3;
  logic signed [PW-1:0] p1, p2, p3;
  logic signed [SW-1:0] r1_r, r2_r, bl;
  logic signed [SW-1:0] oct_r;
  logic [4:0] sh;

  // Scale by 2^OCT and split into lattice index and fraction
  assign sx = ovn_pkg::LAT_W'(x_coord) << OCT;
  assign sy = ovn_pkg::LAT_W'(y_coord) << OCT;
  assign xi = sx >> FRAC_BITS;
  assign yi = sy >> FRAC_BITS;

  for (genvar k = 0; k < 4; k++) begin : g_lat
    assign lx[k] = xi + ovn_pkg::LAT_W'(k) - ovn_pkg::LAT_W'(1);
    assign ly[k] = yi + ovn_pkg::LAT_W'(k) - ovn_pkg::LAT_W'(1);
  end

  // Hash the 4x4 neighborhood
  for (genvar gy = 0; gy < 4; gy++) begin : g_row
    for (genvar gx = 0; gx < 4; gx++) begin : g_col
      ovn_hash u_hash (
        .clk     (clk),
        .en      (ctrl.en),
        .lat_x   (lx[gx]),
        .lat_y   (ly[gy]),
        .lat_val (lv[gy][gx])
      );
    end
  end

  // Weight table
  for (genvar g = 0; g < NW; g++) begin : g_wtab
    assign wtab[g] = ovn_pkg::cos_weight(g, FRAC_BITS);
  end

  // Hold the fractions alongside the hash stages
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      fx_r[0] <= sx[FRAC_BITS-1:0];
      fy_r[0] <= sy[FRAC_BITS-1:0];
      for (int k = 1; k < 4; k++) begin
        fx_r[k] <= fx_r[k-1];
        fy_r[k] <= fy_r[k-1];
      end
    end
  end

  // Smooth the four corner points of the cell
  for (genvar p = 0; p < 4; p++) begin : g_smooth
    localparam int CX = (p % 2) + 1;
    localparam int CY = (p / 2) + 1;
    logic signed [SW-1:0] corners, sides, center;
    assign corners = SW'(lv[CY-1][CX-1]) + SW'(lv[CY+1][CX-1])
                   + SW'(lv[CY-1][CX+1]) + SW'(lv[CY+1][CX+1]);
    assign sides = SW'(lv[CY][CX-1]) + SW'(lv[CY-1][CX])
                 + SW'(lv[CY][CX+1]) + SW'(lv[CY+1][CX]);
    assign center = SW'(lv[CY][CX]);
    assign sm[p] = corners + (sides <<< 1) + (center <<< 2);
  end

  // Blend along x
  assign d1 = (SW + 1)'(sm_r[1]) - (SW + 1)'(sm_r[0]);
  assign d2 = (SW + 1)'(sm_r[3]) - (SW + 1)'(sm_r[2]);
  assign p1 = PW'(d1) * PW'($signed({1'b0, wx_r}));
  assign p2 = PW'(d2) * PW'($signed({1'b0, wx_r}));

  // Blend along y and scale by the octave amplitude
  assign d3 = (SW + 1)'(r2_r) - (SW + 1)'(r1_r);
  assign p3 = PW'(d3) * PW'($signed({1'b0, wy2_r}));
  assign bl = r1_r + SW'(p3 >>> 16);
  assign sh = 5'(OCT * int'(ctrl.pshift));

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      for (int k = 0; k < 4; k++) begin
        sm_r[k] <= sm[k];
      end
      wx_r <= wtab[fx_r[3]];
      wy_r <= wtab[fy_r[3]];
      r1_r <= sm_r[0] + SW'(p1 >>> 16);
      r2_r <= sm_r[2] + SW'(p2 >>> 16);
      wy2_r <= wy_r;
      oct_r <= bl >>> sh;
    end
  end

  assign oct_val = oct_r;

endmodule

// File: hw/rtl/octave_value_noise_2d.sv
// Items pass hash, smoothing, x blend, y blend, half-sum and output registers.
// One item per cycle when not stalled; every octave has its own pipeline lane.
// A stalled output freezes all stages together; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears the valid bits and loads
// octave_count 8, persist_shift 1, abs_enable 1.
// ----------------------------------------------------------------------------
// octave_value_noise_2d
// Fractal 2D value noise, one sample per cycle while out_ch is not stalled,
// enabled octave lanes summed, optionally made absolute, saturated to Q2.17.
// ----------------------------------------------------------------------------
`include "octave_value_noise_2d_defines.svh"

module octave_value_noise_2d #(
  parameter int FRAC_BITS = 8,
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ovn_in_if.sink      in_ch,
  ovn_out_if.source   out_ch,
  ovn_cfg_if.sink     cfg_ch
);

  localparam int DEPTH = 9;

  logic [3:0] oct_cnt_r;
  logic [1:0] pshift_r;
  logic       abs_en_r;
  logic [DEPTH-1:0] v_r;
  logic adv;
  ovn_pkg::oct_ctrl_t ctrl;
  logic signed [ovn_pkg::SMOOTH_W-1:0] oct_val [MAX_OCTAVES];
  logic signed [ovn_pkg::SUM4_W-1:0] lo_nxt, hi_nxt, lo_r, hi_r;
  logic signed [ovn_pkg::ACC_W-1:0] acc, mag, scaled;
  logic signed [ovn_pkg::NOISE_W-1:0] noise_nxt, noise_r;

  // Advance when the output register is empty or being taken
  assign adv = !v_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign cfg_ch.ready = 1'b1;
  assign ctrl = {adv, pshift_r};

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= 4'd8;
      pshift_r <= 2'd1;
      abs_en_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ovn_pkg::REG_OCTAVE_COUNT:  oct_cnt_r <= cfg_ch.data;
        ovn_pkg::REG_PERSIST_SHIFT: pshift_r <= cfg_ch.data[1:0];
        ovn_pkg::REG_ABS_ENABLE:    abs_en_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[DEPTH-2:0], in_ch.valid};
    end
  end

  // Octave lanes
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    ovn_octave #(
      .FRAC_BITS (FRAC_BITS),
      .OCT       (i)
    ) u_oct (
      .clk     (clk),
      .ctrl    (ctrl),
      .x_coord (in_ch.x_coord),
      .y_coord (in_ch.y_coord),
      .oct_val (oct_val[i])
    );
  end

  // Sum the enabled octaves in two halves
  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (4'(i) < oct_cnt_r) begin
        if (i < 4) begin
          lo_nxt = lo_nxt + ovn_pkg::SUM4_W'(oct_val[i]);
        end else begin
          hi_nxt = hi_nxt + ovn_pkg::SUM4_W'(oct_val[i]);
        end
      end
    end
  end

  // Final add, optional magnitude, scale and saturate
  always_comb begin
    acc = ovn_pkg::ACC_W'(lo_r) + ovn_pkg::ACC_W'(hi_r);
    mag = (abs_en_r && acc[ovn_pkg::ACC_W-1]) ? -acc : acc;
    scaled = mag >>> ovn_pkg::OUT_SHIFT;
    priority if (scaled > ovn_pkg::ACC_W'(ovn_pkg::NOISE_MAX)) begin
      noise_nxt = ovn_pkg::NOISE_MAX;
    end else if (scaled < ovn_pkg::ACC_W'(ovn_pkg::NOISE_MIN)) begin
      noise_nxt = ovn_pkg::NOISE_MIN;
    end else begin
      noise_nxt = ovn_pkg::NOISE_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      noise_r <= noise_nxt;
    end
  end

  assign out_ch.valid = v_r[DEPTH-1];
  assign out_ch.noise_value = noise_r;

  // Checks
  `OVN_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready, v_r[0])
  `OVN_ASSERT_NEXT(a_stall_freezes, !adv, $stable(v_r))
  `OVN_ASSERT_NEXT(a_last_to_out, v_r[DEPTH-2] && adv, out_ch.valid)

endmodule
